>>> hdl/rsfp_pkg.sv
// Shared types and constants for the radar status frame parser.
package rsfp_pkg;

  // Frame framing constants
  localparam logic [7:0]  SOF_BYTE        = 8'h01;
  localparam logic [15:0] HEADER_LAST     = 16'd7;
  localparam logic [7:0]  STATUS_NORMAL   = 8'h00;
  localparam logic [7:0]  STATUS_FALL     = 8'h01;

  // Configuration register reset values
  localparam logic [15:0] TARGET_TYPE_RST = 16'h0E02;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd247;

  // Configuration register indexes
  typedef enum logic {
    CFG_TARGET_TYPE = 1'b0,
    CFG_MAX_PAYLOAD = 1'b1
  } cfg_index_t;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_DATA = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  // Frame outcome codes
  typedef enum logic [2:0] {
    OC_NORMAL   = 3'd0,
    OC_FALL     = 3'd1,
    OC_UNKNOWN  = 3'd2,
    OC_HDR_ERR  = 3'd3,
    OC_DATA_ERR = 3'd4,
    OC_LEN_ERR  = 3'd5
  } outcome_t;

  // One result word
  typedef struct packed {
    outcome_t    outcome;
    logic [7:0]  status_value;
    logic [15:0] data_length;
  } result_t;

  // Handoff from the parser step to the result register
  typedef struct packed {
    logic    valid;
    result_t res;
  } result_req_t;

endpackage

>>> hdl/radar_status_frame_parser.sv
// Radar status frame parser: byte input register, parser step, result register.
// A byte that ends a frame is held in the input register, then the parser step loads its
// result word into the result register. Throughput: one byte per cycle while in_ready is high.
// in_ready falls only while the input register is full and the result register
// holds a word that out_ready does not take in that cycle.
// Reset (rst, synchronous): parser hunts for a start byte, registers return to
// target_type 0x0E02 and max_payload 247, and both pipeline registers empty.
module radar_status_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  outcome,
  output logic [7:0]  status_value,
  output logic [15:0] data_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic        stage_valid;
  logic [7:0]  stage_byte;
  logic        advance;
  logic        res_free;
  logic [15:0] target_type;
  logic [15:0] max_payload;
  rsfp_pkg::result_req_t req;
  rsfp_pkg::result_t     res;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_type <= rsfp_pkg::TARGET_TYPE_RST;
      max_payload <= rsfp_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      case (rsfp_pkg::cfg_index_t'(cfg_index))
        rsfp_pkg::CFG_TARGET_TYPE: target_type <= cfg_data;
        rsfp_pkg::CFG_MAX_PAYLOAD: max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  // Process the held word whenever the result register has room
  assign advance  = stage_valid && res_free;
  assign in_ready = !stage_valid || res_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= rx_byte;
    end
  end

  rsfp_step u_step (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .rx_byte     (stage_byte),
    .target_type (target_type),
    .max_payload (max_payload),
    .req         (req)
  );

  rsfp_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .load      (advance),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (res_free),
    .res       (res)
  );

  assign outcome      = res.outcome;
  assign status_value = res.status_value;
  assign data_length  = res.data_length;

endmodule

>>> hdl/rsfp_step.sv
// Parser state and the per-byte update logic.
module rsfp_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  input  logic [15:0]         target_type,
  input  logic [15:0]         max_payload,
  output rsfp_pkg::result_req_t req
);

  rsfp_pkg::phase_t phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] length_field, length_field_next;
  logic [15:0] type_field, type_field_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  first_data_byte, first_data_byte_next;

  // Hold parser state, advance on each processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= rsfp_pkg::PH_HUNT;
      byte_count      <= '0;
      length_field    <= '0;
      type_field      <= '0;
      running_xor     <= '0;
      first_data_byte <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      length_field    <= length_field_next;
      type_field      <= type_field_next;
      running_xor     <= running_xor_next;
      first_data_byte <= first_data_byte_next;
    end
  end

  // Compute next state and any frame result for the current byte
  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    length_field_next    = length_field;
    type_field_next      = type_field;
    running_xor_next     = running_xor;
    first_data_byte_next = first_data_byte;
    req.valid            = 1'b0;
    req.res.outcome      = rsfp_pkg::OC_NORMAL;
    req.res.status_value = 8'h00;
    req.res.data_length  = length_field;

    case (phase)
      rsfp_pkg::PH_HEAD: begin
        if (byte_count < rsfp_pkg::HEADER_LAST) begin
          running_xor_next = running_xor ^ rx_byte;
          case (byte_count[2:0])
            3'd3:    length_field_next = {rx_byte, length_field[7:0]};
            3'd4:    length_field_next = {length_field[15:8], rx_byte};
            3'd5:    type_field_next   = {rx_byte, type_field[7:0]};
            3'd6:    type_field_next   = {type_field[15:8], rx_byte};
            default: ;
          endcase
          byte_count_next = byte_count + 16'd1;
        end else if (~running_xor != rx_byte) begin
          // Bad header checksum: report and drop back to hunting
          req.valid       = 1'b1;
          req.res.outcome = rsfp_pkg::OC_HDR_ERR;
          phase_next      = rsfp_pkg::PH_HUNT;
        end else if (length_field > max_payload) begin
          req.valid       = 1'b1;
          req.res.outcome = rsfp_pkg::OC_LEN_ERR;
          phase_next      = rsfp_pkg::PH_HUNT;
        end else begin
          byte_count_next      = '0;
          running_xor_next     = '0;
          first_data_byte_next = '0;
          if (length_field == 16'd0) begin
            phase_next = rsfp_pkg::PH_HUNT;
          end else if (type_field == target_type) begin
            phase_next = rsfp_pkg::PH_DATA;
          end else begin
            phase_next = rsfp_pkg::PH_SKIP;
          end
        end
      end

      rsfp_pkg::PH_DATA: begin
        if (byte_count < length_field) begin
          if (byte_count == 16'd0) begin
            first_data_byte_next = rx_byte;
          end
          running_xor_next = running_xor ^ rx_byte;
          byte_count_next  = byte_count + 16'd1;
        end else begin
          // Data checksum byte ends the target frame
          req.valid            = 1'b1;
          req.res.status_value = first_data_byte;
          phase_next           = rsfp_pkg::PH_HUNT;
          if (~running_xor != rx_byte) begin
            req.res.outcome = rsfp_pkg::OC_DATA_ERR;
          end else if (first_data_byte == rsfp_pkg::STATUS_NORMAL) begin
            req.res.outcome = rsfp_pkg::OC_NORMAL;
          end else if (first_data_byte == rsfp_pkg::STATUS_FALL) begin
            req.res.outcome = rsfp_pkg::OC_FALL;
          end else begin
            req.res.outcome = rsfp_pkg::OC_UNKNOWN;
          end
        end
      end

      rsfp_pkg::PH_SKIP: begin
        if (byte_count < length_field) begin
          byte_count_next = byte_count + 16'd1;
        end else begin
          phase_next = rsfp_pkg::PH_HUNT;
        end
      end

      default: begin
        // Hunt for the start byte
        if (rx_byte == rsfp_pkg::SOF_BYTE) begin
          running_xor_next  = rx_byte;
          byte_count_next   = 16'd1;
          length_field_next = '0;
          type_field_next   = '0;
          phase_next        = rsfp_pkg::PH_HEAD;
        end
      end
    endcase
  end

endmodule

>>> hdl/rsfp_result_reg.sv
// Output register holding one result word until it is taken.
module rsfp_result_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  rsfp_pkg::result_req_t req,
  input  logic                  load,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  free,
  output rsfp_pkg::result_t     res
);

  // Room for a new word when empty or when the held word leaves now
  assign free = !out_valid || out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load && req.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (load && req.valid) begin
      res <= req.res;
    end
  end

endmodule

>>> sim/tb_radar_status_frame_parser.sv
// Self-checking testbench for the radar status frame parser.
module tb_radar_status_frame_parser;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_GAP      = 13;

  // One directed frame: leading noise, header fields, data, corruption, known report
  typedef struct {
    int                 noise;
    logic [7:0]         noise_byte;
    int                 len;
    logic [15:0]        typ;
    logic [7:0]         first;
    bit                 hdr_bad;
    bit                 data_bad;
    logic [7:0]         id;
    bit                 typed;
    rsfp_pkg::outcome_t oc;
    logic [7:0]         status;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  outcome;
  logic [7:0]  status_value;
  logic [15:0] data_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  // Parser mirror: configuration and frame state
  logic [15:0]      cfg_target;
  logic [15:0]      cfg_max;
  rsfp_pkg::phase_t ps_phase;
  logic [15:0]      ps_count;
  logic [15:0]      ps_len;
  logic [15:0]      ps_type;
  logic [7:0]       ps_xor;
  logic [7:0]       ps_first;
  logic             ps_target;

  rsfp_pkg::result_t pending_reports[$];
  rsfp_pkg::result_t want;
  logic [7:0]        frame_bytes[$];
  frame_row_t        rows[15];
  bit                calm;
  int                error_count;
  int                cycle_count;

  radar_status_frame_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .outcome      (outcome),
    .status_value (status_value),
    .data_length  (data_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (calm) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void parser_reset();
    cfg_target = rsfp_pkg::TARGET_TYPE_RST;
    cfg_max    = rsfp_pkg::MAX_PAYLOAD_RST;
    ps_phase   = rsfp_pkg::PH_HUNT;
    ps_count   = '0;
    ps_len     = '0;
    ps_type    = '0;
    ps_xor     = '0;
    ps_first   = '0;
    ps_target  = 1'b0;
  endfunction

  // Advance the parser mirror by one byte; return 1 when a frame report is due
  function automatic bit parse_byte(input logic [7:0] b, output rsfp_pkg::result_t r);
    r = '0;
    r.data_length = ps_len;
    case (ps_phase)
      rsfp_pkg::PH_HEAD: begin
        if (ps_count < rsfp_pkg::HEADER_LAST) begin
          ps_xor = ps_xor ^ b;
          case (ps_count)
            16'd3: ps_len[15:8] = b;
            16'd4: ps_len[7:0] = b;
            16'd5: ps_type[15:8] = b;
            16'd6: ps_type[7:0] = b;
            default: ;
          endcase
          ps_count = ps_count + 16'd1;
          return 1'b0;
        end
        if (~ps_xor != b) begin
          r.outcome = rsfp_pkg::OC_HDR_ERR;
          ps_phase = rsfp_pkg::PH_HUNT;
          return 1'b1;
        end
        if (ps_len > cfg_max) begin
          r.outcome = rsfp_pkg::OC_LEN_ERR;
          ps_phase = rsfp_pkg::PH_HUNT;
          return 1'b1;
        end
        ps_target = (ps_type == cfg_target);
        ps_count = '0;
        ps_xor = '0;
        ps_first = '0;
        if (ps_len == 16'd0) ps_phase = rsfp_pkg::PH_HUNT;
        else ps_phase = ps_target ? rsfp_pkg::PH_DATA : rsfp_pkg::PH_SKIP;
        return 1'b0;
      end
      rsfp_pkg::PH_DATA: begin
        if (ps_count < ps_len) begin
          if (ps_count == 16'd0) ps_first = b;
          ps_xor = ps_xor ^ b;
          ps_count = ps_count + 16'd1;
          return 1'b0;
        end
        if (~ps_xor != b) r.outcome = rsfp_pkg::OC_DATA_ERR;
        else if (ps_first == rsfp_pkg::STATUS_NORMAL) r.outcome = rsfp_pkg::OC_NORMAL;
        else if (ps_first == rsfp_pkg::STATUS_FALL) r.outcome = rsfp_pkg::OC_FALL;
        else r.outcome = rsfp_pkg::OC_UNKNOWN;
        r.status_value = ps_first;
        ps_phase = rsfp_pkg::PH_HUNT;
        return 1'b1;
      end
      rsfp_pkg::PH_SKIP: begin
        if (ps_count < ps_len) ps_count = ps_count + 16'd1;
        else ps_phase = rsfp_pkg::PH_HUNT;
        return 1'b0;
      end
      default: begin
        if (b == rsfp_pkg::SOF_BYTE) begin
          ps_xor = b;
          ps_count = 16'd1;
          ps_len = '0;
          ps_type = '0;
          ps_target = 1'b0;
          ps_phase = rsfp_pkg::PH_HEAD;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Send one word; hold valid high into the next word when there is no gap
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input rsfp_pkg::result_t known);
    int gap;
    rsfp_pkg::result_t r;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (parse_byte(b, r)) pending_reports.push_back(typed ? known : r);
  endtask

  // Assemble a frame: header, then data and data checksum when the parser will take them
  task automatic build_frame(input int len, input logic [15:0] typ, input logic [7:0] first,
                             input bit hdr_bad, input bit data_bad, input logic [7:0] id);
    logic [7:0]  hdr[8];
    logic [15:0] ln;
    logic [7:0]  x;
    logic [7:0]  d;
    ln = len[15:0];
    hdr[0] = rsfp_pkg::SOF_BYTE;
    hdr[1] = id;
    hdr[2] = 8'($urandom);
    hdr[3] = ln[15:8];
    hdr[4] = ln[7:0];
    hdr[5] = typ[15:8];
    hdr[6] = typ[7:0];
    x = '0;
    for (int i = 0; i < 7; i++) x = x ^ hdr[i];
    hdr[7] = ~x;
    if (hdr_bad) hdr[7] = hdr[7] ^ (8'h01 << $urandom_range(0, 7));
    frame_bytes.delete();
    for (int i = 0; i < 8; i++) frame_bytes.push_back(hdr[i]);
    if (!hdr_bad && ln != 16'd0 && ln <= cfg_max) begin
      x = '0;
      for (int i = 0; i < len; i++) begin
        d = (i == 0) ? first : 8'($urandom);
        x = x ^ d;
        frame_bytes.push_back(d);
      end
      d = ~x;
      if (data_bad) d = d ^ (8'h01 << $urandom_range(0, 7));
      frame_bytes.push_back(d);
    end
  endtask

  task automatic send_frame(input int count, input bit typed, input rsfp_pkg::result_t known);
    for (int i = 0; i < count; i++) send_byte(frame_bytes[i], typed, known);
  endtask

  // Drop valid and wait until every report is in and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input rsfp_pkg::cfg_index_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (idx == rsfp_pkg::CFG_TARGET_TYPE) cfg_target = val;
    else cfg_max = val;
  endtask

  task automatic set_config(input logic [15:0] target, input logic [15:0] max_len);
    settle();
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(rsfp_pkg::CFG_TARGET_TYPE, target);
      cfg_write(rsfp_pkg::CFG_MAX_PAYLOAD, max_len);
    end else begin
      cfg_write(rsfp_pkg::CFG_MAX_PAYLOAD, max_len);
      cfg_write(rsfp_pkg::CFG_TARGET_TYPE, target);
    end
    cfg_valid <= 1'b0;
  endtask

  // Sink side: random stall before each word
  initial begin
    int gap;
    out_ready <= 1'b0;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!(out_valid && !rst)) @(negedge clk);
      @(posedge clk);
    end
  end

  // Compare each accepted report with the oldest expected one
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report outcome %0d status %0d length %0d",
                 $realtime, outcome, status_value, data_length);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (outcome !== want.outcome) begin
          $display("%0t: outcome expected %0d got %0d", $realtime, want.outcome, outcome);
          error_count++;
        end
        if (status_value !== want.status_value) begin
          $display("%0t: status_value expected %0d got %0d",
                   $realtime, want.status_value, status_value);
          error_count++;
        end
        if (data_length !== want.data_length) begin
          $display("%0t: data_length expected %0d got %0d",
                   $realtime, want.data_length, data_length);
          error_count++;
        end
      end
    end
  end

  initial begin
    rsfp_pkg::result_t known;
    int                len;
    int                cap;
    int                sel;
    int                cut;
    int                phase_bytes;
    logic [15:0]       typ;
    logic [15:0]       target;
    logic [15:0]       max_len;
    logic [7:0]        first;

    error_count = 0;
    cycle_count = 0;
    calm = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    rx_byte   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= rsfp_pkg::CFG_TARGET_TYPE;
    cfg_data  <= '0;
    parser_reset();

    // Directed frames under reset configuration
    rows[0]  = '{1, 8'hFF, 1,   16'h0E02, 8'h00, 0, 0, 8'h00, 1, rsfp_pkg::OC_NORMAL, 8'h00};
    rows[1]  = '{1, 8'h00, 1,   16'h0E02, 8'h01, 0, 0, 8'hFF, 1, rsfp_pkg::OC_FALL, 8'h01};
    rows[2]  = '{0, 8'h00, 1,   16'h0E02, 8'hFF, 0, 0, 8'h00, 1, rsfp_pkg::OC_UNKNOWN, 8'hFF};
    rows[3]  = '{0, 8'h00, 3,   16'h0E02, 8'h02, 0, 0, 8'hFF, 1, rsfp_pkg::OC_UNKNOWN, 8'h02};
    rows[4]  = '{0, 8'h00, 1,   16'h0E02, 8'h00, 1, 0, 8'h00, 1, rsfp_pkg::OC_HDR_ERR, 8'h00};
    rows[5]  = '{0, 8'h00, 248, 16'h0E02, 8'h00, 0, 0, 8'hFF, 1, rsfp_pkg::OC_LEN_ERR, 8'h00};
    rows[6]  = '{0, 8'h00, 65535, 16'h1234, 8'h00, 0, 0, 8'h00, 1, rsfp_pkg::OC_LEN_ERR,
                 8'h00};
    rows[7]  = '{0, 8'h00, 2,   16'h0E02, 8'h01, 0, 1, 8'hFF, 1, rsfp_pkg::OC_DATA_ERR,
                 8'h01};
    rows[8]  = '{2, 8'hFE, 0,   16'h0E02, 8'h00, 0, 0, 8'h00, 0, rsfp_pkg::OC_NORMAL, 8'h00};
    rows[9]  = '{0, 8'h00, 4,   16'hFFFF, 8'h01, 0, 0, 8'hFF, 0, rsfp_pkg::OC_NORMAL, 8'h00};
    rows[10] = '{0, 8'h00, 247, 16'h0E02, 8'h5A, 0, 0, 8'h00, 0, rsfp_pkg::OC_NORMAL, 8'h00};
    rows[11] = '{0, 8'h00, 0,   16'h7777, 8'h00, 0, 0, 8'hFF, 0, rsfp_pkg::OC_NORMAL, 8'h00};
    rows[12] = '{0, 8'h00, 5,   16'h0000, 8'h00, 0, 0, 8'h00, 0, rsfp_pkg::OC_NORMAL, 8'h00};
    rows[13] = '{0, 8'h00, 2,   16'hAAAA, 8'h00, 1, 0, 8'hFF, 1, rsfp_pkg::OC_HDR_ERR, 8'h00};
    rows[14] = '{0, 8'h00, 247, 16'h5555, 8'h00, 0, 0, 8'h00, 0, rsfp_pkg::OC_NORMAL, 8'h00};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      known = '0;
      known.outcome = rows[i].oc;
      known.status_value = rows[i].status;
      known.data_length = rows[i].len[15:0];
      for (int k = 0; k < rows[i].noise; k++) send_byte(rows[i].noise_byte, 1'b0, known);
      build_frame(rows[i].len, rows[i].typ, rows[i].first, rows[i].hdr_bad,
                  rows[i].data_bad, rows[i].id);
      send_frame(frame_bytes.size(), rows[i].typed, known);
    end

    // Narrowest length limit and all-ones target
    set_config(16'hFFFF, 16'd1);
    known = '0;
    build_frame(1, 16'hFFFF, rsfp_pkg::STATUS_FALL, 0, 0, 8'h33);
    send_frame(frame_bytes.size(), 1'b0, known);
    build_frame(2, 16'hFFFF, 8'h00, 0, 0, 8'hCC);
    send_frame(frame_bytes.size(), 1'b0, known);

    // Widest length limit, zero target, one long skipped frame
    set_config(16'h0000, 16'hFFFF);
    calm = 1'b1;
    build_frame(300, 16'h5555, 8'h00, 0, 0, 8'h00);
    send_frame(frame_bytes.size(), 1'b0, known);
    calm = 1'b0;
    build_frame(3, 16'h0000, rsfp_pkg::STATUS_NORMAL, 0, 0, 8'hFF);
    send_frame(frame_bytes.size(), 1'b0, known);

    // Random frames over several configurations
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 3))
        0: target = rsfp_pkg::TARGET_TYPE_RST;
        1: target = 16'h0000;
        2: target = 16'hFFFF;
        default: target = 16'($urandom);
      endcase
      case (p == 0 ? 1 : $urandom_range(0, 3))
        0: max_len = 16'd1;
        1: max_len = rsfp_pkg::MAX_PAYLOAD_RST;
        2: max_len = 16'hFFFF;
        default: max_len = 16'($urandom_range(2, 40));
      endcase
      set_config(target, max_len);
      phase_bytes = 0;
      while (phase_bytes < 115) begin
        calm = ($urandom_range(0, 4) == 0);
        cap = (int'(cfg_max) > 12) ? 12 : int'(cfg_max);
        sel = $urandom_range(0, 99);
        if (sel < 8) len = 0;
        else if (sel < 85) len = $urandom_range(1, cap);
        else if (sel < 93) len = (int'(cfg_max) <= 64) ? int'(cfg_max) : $urandom_range(13, 64);
        else if (cfg_max != 16'hFFFF) begin
          len = int'(cfg_max) + $urandom_range(1, 20);
          if (len > 65535) len = 65535;
        end else len = $urandom_range(1, cap);
        typ = ($urandom_range(0, 99) < 65) ? cfg_target : 16'($urandom);
        sel = $urandom_range(0, 2);
        first = (sel == 0) ? rsfp_pkg::STATUS_NORMAL :
                (sel == 1) ? rsfp_pkg::STATUS_FALL : 8'($urandom);
        // Noise between frames
        for (int k = $urandom_range(0, 3); k > 0; k--) send_byte(8'($urandom), 1'b0, known);
        build_frame(len, typ, first, $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 8,
                    8'($urandom));
        // Now and then cut a frame short
        cut = frame_bytes.size();
        if ($urandom_range(0, 19) == 0) cut = $urandom_range(1, frame_bytes.size() - 1);
        send_frame(cut, 1'b0, known);
        phase_bytes += cut;
      end
      calm = 1'b0;
    end

    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
